[sv/assert_macros.svh]
// ---------------------------------------------------------------------------
// assertion macros
// concurrent assertion wrappers, empty when built for synthesis
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define SAWLC_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");
`define SAWLC_ASSERT_NEVER(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("forbidden condition");
`else
`define SAWLC_ASSERT(label, clk, rst, prop)
`define SAWLC_ASSERT_NEVER(label, clk, rst, expr)
`endif

`endif

[sv/sawlc_pkg.sv]
// ---------------------------------------------------------------------------
// sawlc package
// shared types and constants of the write-back lru cache
// ---------------------------------------------------------------------------
package sawlc_pkg;

   localparam int MEM_WORDS_DEF       = 65536;
   localparam int MAX_LINES_DEF       = 256;
   localparam int MAX_BLOCK_WORDS_DEF = 16;
   localparam int MAX_WAYS_DEF        = 16;

   localparam int TAG_W  = 16;
   localparam int DATA_W = 32;

   localparam logic [1:0] OP_PRELOAD = 2'd0;
   localparam logic [1:0] OP_READ    = 2'd1;
   localparam logic [1:0] OP_WRITE   = 2'd2;

   localparam logic [1:0] CSR_BLOCK_WORDS_LOG2 = 2'd0;
   localparam logic [1:0] CSR_SETS_LOG2        = 2'd1;
   localparam logic [1:0] CSR_WAYS_LOG2        = 2'd2;

   typedef enum logic [2:0] {
      KIND_TO_PROC   = 3'd0,
      KIND_FROM_PROC = 3'd1,
      KIND_FILL      = 3'd2,
      KIND_WRITEBACK = 3'd3,
      KIND_DROP      = 3'd4
   } kind_type;

   typedef struct packed {
      logic [3:0] bl;
      logic [3:0] sl;
      logic [3:0] wl;
   } geom_type;

   typedef struct packed {
      kind_type                  kind;
      logic [15:0]               start;
      logic [4:0]                words;
      logic [DATA_W-1:0]         data;
      logic                      last;
   } rec_type;

endpackage

[sv/sawlc_if.sv]
// ---------------------------------------------------------------------------
// sawlc channel interfaces
// request and response channels with valid/ready handshake
// ---------------------------------------------------------------------------
interface sawlc_req_if;
   logic               valid;
   logic               ready;
   logic [1:0]         operation;
   logic [15:0]        word_address;
   logic signed [31:0] write_data;

   modport source (output valid, operation, word_address, write_data, input ready);
   modport sink   (input valid, operation, word_address, write_data, output ready);
endinterface

interface sawlc_rsp_if;
   logic               valid;
   logic               ready;
   logic [2:0]         transfer_kind;
   logic [15:0]        start_address;
   logic [4:0]         transfer_words;
   logic signed [31:0] read_data;
   logic               last;

   modport source (output valid, transfer_kind, start_address, transfer_words, read_data,
                   last, input ready);
   modport sink   (input valid, transfer_kind, start_address, transfer_words, read_data,
                   last, output ready);
endinterface

[sv/sawlc_ram.sv]
// ---------------------------------------------------------------------------
// sawlc ram
// generic simple dual-port ram, one write port, one registered read port
// ---------------------------------------------------------------------------
module sawlc_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                     clock,
   input  logic                     write_enable,
   input  logic [ADDR_W-1:0]        write_address,
   input  logic [WIDTH-1:0]         write_data,
   input  logic                     read_enable,
   input  logic [ADDR_W-1:0]        read_address,
   output logic [WIDTH-1:0]         read_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] read_data_ff;

   always_ff @(posedge clock) begin
      if (write_enable) begin
         mem_ff[write_address] <= write_data;
      end
      if (read_enable) begin
         read_data_ff <= mem_ff[read_address];
      end
   end

   assign read_data = read_data_ff;

endmodule

[sv/sawlc_ctrl.sv]
// ---------------------------------------------------------------------------
// sawlc control
// access sequencer: tag scan, lru update, write-back, fill and word access
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module sawlc_ctrl import sawlc_pkg::*; #(
   parameter int MEM_WORDS       = MEM_WORDS_DEF,
   parameter int MAX_LINES       = MAX_LINES_DEF,
   parameter int MAX_BLOCK_WORDS = MAX_BLOCK_WORDS_DEF,
   parameter int MAX_WAYS        = MAX_WAYS_DEF
) (
   input  logic          clock,
   input  logic          reset,
   input  geom_type      geom,
   input  logic          invalidate,
   sawlc_req_if.sink     req_ch,
   input  logic          slot_free,
   output logic          emit,
   output rec_type       rec
);
   localparam int WAY_W   = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
   localparam int AGE_W   = WAY_W;
   localparam int LINE_W  = (MAX_LINES > 1) ? $clog2(MAX_LINES) : 1;
   localparam int WORD_W  = (MAX_BLOCK_WORDS > 1) ? $clog2(MAX_BLOCK_WORDS) : 1;
   localparam int DWORDS  = MAX_LINES * MAX_BLOCK_WORDS;
   localparam int DADDR_W = (DWORDS > 1) ? $clog2(DWORDS) : 1;
   localparam int MEM_W   = $clog2(MEM_WORDS);
   localparam int META_W  = TAG_W + 1 + AGE_W;

   typedef struct packed {
      logic [TAG_W-1:0] tag;
      logic             dirty;
      logic [AGE_W-1:0] age;
   } meta_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_LOOK, ST_LOOK_DRAIN, ST_DECIDE, ST_TOUCH, ST_TOUCH_DRAIN,
      ST_EVICT, ST_EVICT_DRAIN, ST_EVICT_EMIT, ST_FILL, ST_FILL_DRAIN,
      ST_FILL_EMIT, ST_ACCESS, ST_ACCESS_WAIT
   } state_type;

   function automatic logic [LINE_W-1:0] line_of(input logic [LINE_W-1:0] base,
                                                 input logic [WAY_W-1:0] way);
      line_of = base | LINE_W'(way);
   endfunction

   function automatic logic [DADDR_W-1:0] daddr(input logic [LINE_W-1:0] line,
                                                input logic [WORD_W-1:0] word);
      daddr = DADDR_W'(DADDR_W'(line) * DADDR_W'(MAX_BLOCK_WORDS)) + DADDR_W'(word);
   endfunction

   state_type           state_ff, state_in;
   logic [1:0]          op_ff, op_in;
   logic [15:0]         addr_ff, addr_in;
   logic [DATA_W-1:0]   wdata_ff, wdata_in;
   logic [3:0]          bl_ff, bl_in;
   logic [3:0]          wl_ff, wl_in;
   logic [TAG_W-1:0]    block_ff, block_in;
   logic [LINE_W-1:0]   base_ff, base_in;
   logic [WAY_W-1:0]    idx_ff, idx_in;
   logic [WORD_W-1:0]   word_ff, word_in;
   logic                pipe_vld_ff, pipe_vld_in;
   logic [WAY_W-1:0]    pipe_way_ff, pipe_way_in;
   logic [WORD_W-1:0]   pipe_word_ff, pipe_word_in;
   logic                hit_ff, hit_in;
   logic [WAY_W-1:0]    hit_way_ff, hit_way_in;
   logic                hit_dirty_ff, hit_dirty_in;
   logic [AGE_W-1:0]    hit_age_ff, hit_age_in;
   logic                inv_ff, inv_in;
   logic [WAY_W-1:0]    inv_way_ff, inv_way_in;
   logic [WAY_W-1:0]    best_way_ff, best_way_in;
   logic [AGE_W-1:0]    best_age_ff, best_age_in;
   logic [TAG_W-1:0]    best_tag_ff, best_tag_in;
   logic                best_dirty_ff, best_dirty_in;
   logic [WAY_W-1:0]    way_ff, way_in;
   logic                was_valid_ff, was_valid_in;
   logic [AGE_W-1:0]    old_age_ff, old_age_in;
   logic [MAX_LINES-1:0] valid_ff, valid_in;

   logic                meta_we, meta_re;
   logic [LINE_W-1:0]   meta_waddr, meta_raddr;
   logic [META_W-1:0]   meta_wdata, meta_rdata;
   logic                data_we, data_re;
   logic [DADDR_W-1:0]  data_waddr, data_raddr;
   logic [DATA_W-1:0]   data_wdata, data_rdata;
   logic                mem_we, mem_re;
   logic [MEM_W-1:0]    mem_waddr, mem_raddr;
   logic [DATA_W-1:0]   mem_wdata, mem_rdata;

   meta_type            meta_q, meta_new;
   logic [LINE_W-1:0]   pipe_line, sel_line;
   logic                pipe_valid;
   logic [WAY_W-1:0]    way_mask;
   logic [WORD_W-1:0]   blk_mask;
   logic [15:0]         vstart, fstart, set_bits;
   logic [4:0]          blk_words;
   logic                new_dirty;

   sawlc_ram #(.WIDTH(META_W), .DEPTH(MAX_LINES)) u_meta_ram (
      .clock, .write_enable(meta_we), .write_address(meta_waddr),
      .write_data(meta_wdata), .read_enable(meta_re), .read_address(meta_raddr),
      .read_data(meta_rdata)
   );

   sawlc_ram #(.WIDTH(DATA_W), .DEPTH(DWORDS)) u_data_ram (
      .clock, .write_enable(data_we), .write_address(data_waddr),
      .write_data(data_wdata), .read_enable(data_re), .read_address(data_raddr),
      .read_data(data_rdata)
   );

   sawlc_ram #(.WIDTH(DATA_W), .DEPTH(MEM_WORDS)) u_mem_ram (
      .clock, .write_enable(mem_we), .write_address(mem_waddr),
      .write_data(mem_wdata), .read_enable(mem_re), .read_address(mem_raddr),
      .read_data(mem_rdata)
   );

   assign req_ch.ready = (state_ff == ST_IDLE);

   always_comb begin
      meta_q     = meta_type'(meta_rdata);
      pipe_line  = line_of(base_ff, pipe_way_ff);
      pipe_valid = valid_ff[pipe_line];
      sel_line   = line_of(base_ff, way_ff);
      way_mask   = WAY_W'((32'd1 << wl_ff) - 32'd1);
      blk_mask   = WORD_W'((32'd1 << bl_ff) - 32'd1);
      blk_words  = 5'(32'd1 << bl_ff);
      vstart     = best_tag_ff << bl_ff;
      fstart     = block_ff << bl_ff;
      new_dirty  = (op_ff == OP_WRITE) || (hit_ff && hit_dirty_ff);
      set_bits   = (req_ch.word_address >> geom.bl) & ((16'd1 << geom.sl) - 16'd1);

      state_in      = state_ff;
      op_in         = op_ff;
      addr_in       = addr_ff;
      wdata_in      = wdata_ff;
      bl_in         = bl_ff;
      wl_in         = wl_ff;
      block_in      = block_ff;
      base_in       = base_ff;
      idx_in        = idx_ff;
      word_in       = word_ff;
      pipe_vld_in   = 1'b0;
      pipe_way_in   = pipe_way_ff;
      pipe_word_in  = pipe_word_ff;
      hit_in        = hit_ff;
      hit_way_in    = hit_way_ff;
      hit_dirty_in  = hit_dirty_ff;
      hit_age_in    = hit_age_ff;
      inv_in        = inv_ff;
      inv_way_in    = inv_way_ff;
      best_way_in   = best_way_ff;
      best_age_in   = best_age_ff;
      best_tag_in   = best_tag_ff;
      best_dirty_in = best_dirty_ff;
      way_in        = way_ff;
      was_valid_in  = was_valid_ff;
      old_age_in    = old_age_ff;
      valid_in      = valid_ff;

      meta_we    = 1'b0;
      meta_re    = 1'b0;
      meta_waddr = pipe_line;
      meta_raddr = line_of(base_ff, idx_ff);
      meta_new   = meta_q;
      data_we    = 1'b0;
      data_re    = 1'b0;
      data_waddr = daddr(sel_line, pipe_word_ff);
      data_raddr = daddr(sel_line, word_ff);
      data_wdata = mem_rdata;
      mem_we     = 1'b0;
      mem_re     = 1'b0;
      mem_waddr  = MEM_W'(vstart + 16'(pipe_word_ff));
      mem_raddr  = MEM_W'(fstart + 16'(word_ff));
      mem_wdata  = data_rdata;
      emit       = 1'b0;
      rec        = '0;

      // tag scan result of the previous read
      if (pipe_vld_ff && (state_ff == ST_LOOK || state_ff == ST_LOOK_DRAIN)) begin
         if (pipe_valid && meta_q.tag == block_ff && !hit_ff) begin
            hit_in       = 1'b1;
            hit_way_in   = pipe_way_ff;
            hit_dirty_in = meta_q.dirty;
            hit_age_in   = meta_q.age;
         end
         if (!pipe_valid && !inv_ff) begin
            inv_in     = 1'b1;
            inv_way_in = pipe_way_ff;
         end
         if (pipe_way_ff == '0 || meta_q.age > best_age_ff) begin
            best_way_in   = pipe_way_ff;
            best_age_in   = meta_q.age;
            best_tag_in   = meta_q.tag;
            best_dirty_in = meta_q.dirty;
         end
      end

      // age update write-back
      if (pipe_vld_ff && (state_ff == ST_TOUCH || state_ff == ST_TOUCH_DRAIN)) begin
         meta_we = 1'b1;
         if (pipe_way_ff == way_ff) begin
            meta_new.tag   = block_ff;
            meta_new.dirty = new_dirty;
            meta_new.age   = '0;
         end else if (pipe_valid && (!was_valid_ff || meta_q.age < old_age_ff)) begin
            meta_new.age = meta_q.age + AGE_W'(1);
         end
      end
      meta_wdata = META_W'(meta_new);

      // victim copy to backing memory
      if (pipe_vld_ff && (state_ff == ST_EVICT || state_ff == ST_EVICT_DRAIN)) begin
         mem_we = 1'b1;
      end

      // fill copy into the line
      if (pipe_vld_ff && (state_ff == ST_FILL || state_ff == ST_FILL_DRAIN)) begin
         data_we = 1'b1;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_ch.valid) begin
               if (req_ch.operation == OP_PRELOAD) begin
                  mem_we    = 1'b1;
                  mem_waddr = MEM_W'(req_ch.word_address);
                  mem_wdata = DATA_W'(req_ch.write_data);
               end else if (req_ch.operation == OP_READ || req_ch.operation == OP_WRITE) begin
                  op_in    = req_ch.operation;
                  addr_in  = req_ch.word_address;
                  wdata_in = DATA_W'(req_ch.write_data);
                  bl_in    = geom.bl;
                  wl_in    = geom.wl;
                  block_in = req_ch.word_address >> geom.bl;
                  base_in  = LINE_W'(32'(set_bits) << geom.wl);
                  idx_in   = '0;
                  hit_in   = 1'b0;
                  inv_in   = 1'b0;
                  state_in = ST_LOOK;
               end
            end
         end
         ST_LOOK, ST_TOUCH: begin
            meta_re     = 1'b1;
            pipe_vld_in = 1'b1;
            pipe_way_in = idx_ff;
            if (idx_ff == way_mask) begin
               state_in = (state_ff == ST_LOOK) ? ST_LOOK_DRAIN : ST_TOUCH_DRAIN;
            end else begin
               idx_in = idx_ff + WAY_W'(1);
            end
         end
         ST_LOOK_DRAIN: begin
            state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            idx_in = '0;
            if (hit_ff) begin
               way_in       = hit_way_ff;
               was_valid_in = 1'b1;
               old_age_in   = hit_age_ff;
            end else if (inv_ff) begin
               way_in       = inv_way_ff;
               was_valid_in = 1'b0;
               old_age_in   = '0;
            end else begin
               way_in       = best_way_ff;
               was_valid_in = 1'b1;
               old_age_in   = best_age_ff;
            end
            if (!hit_ff) begin
               valid_in[line_of(base_ff, way_in)] = 1'b1;
            end
            state_in = ST_TOUCH;
         end
         ST_TOUCH_DRAIN: begin
            word_in = '0;
            if (hit_ff) begin
               state_in = ST_ACCESS;
            end else if (!was_valid_ff) begin
               state_in = ST_FILL;
            end else if (best_dirty_ff) begin
               state_in = ST_EVICT;
            end else begin
               state_in = ST_EVICT_EMIT;
            end
         end
         ST_EVICT: begin
            data_re      = 1'b1;
            pipe_vld_in  = 1'b1;
            pipe_word_in = word_ff;
            if (word_ff == blk_mask) begin
               state_in = ST_EVICT_DRAIN;
            end else begin
               word_in = word_ff + WORD_W'(1);
            end
         end
         ST_EVICT_DRAIN: begin
            state_in = ST_EVICT_EMIT;
         end
         ST_EVICT_EMIT: begin
            if (slot_free) begin
               emit      = 1'b1;
               rec.kind  = best_dirty_ff ? KIND_WRITEBACK : KIND_DROP;
               rec.start = vstart;
               rec.words = blk_words;
               word_in   = '0;
               state_in  = ST_FILL;
            end
         end
         ST_FILL: begin
            mem_re       = 1'b1;
            pipe_vld_in  = 1'b1;
            pipe_word_in = word_ff;
            if (word_ff == blk_mask) begin
               state_in = ST_FILL_DRAIN;
            end else begin
               word_in = word_ff + WORD_W'(1);
            end
         end
         ST_FILL_DRAIN: begin
            state_in = ST_FILL_EMIT;
         end
         ST_FILL_EMIT: begin
            if (slot_free) begin
               emit      = 1'b1;
               rec.kind  = KIND_FILL;
               rec.start = fstart;
               rec.words = blk_words;
               state_in  = ST_ACCESS;
            end
         end
         ST_ACCESS: begin
            data_raddr = daddr(sel_line, WORD_W'(addr_ff) & blk_mask);
            data_waddr = data_raddr;
            if (op_ff == OP_READ) begin
               data_re  = 1'b1;
               state_in = ST_ACCESS_WAIT;
            end else if (slot_free) begin
               data_we    = 1'b1;
               data_wdata = wdata_ff;
               emit       = 1'b1;
               rec.kind   = KIND_FROM_PROC;
               rec.start  = addr_ff;
               rec.words  = 5'd1;
               rec.last   = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         ST_ACCESS_WAIT: begin
            if (slot_free) begin
               emit      = 1'b1;
               rec.kind  = KIND_TO_PROC;
               rec.start = addr_ff;
               rec.words = 5'd1;
               rec.data  = data_rdata;
               rec.last  = 1'b1;
               state_in  = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (invalidate) begin
         valid_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      op_in_hold: begin
         op_ff         <= op_in;
         addr_ff       <= addr_in;
         wdata_ff      <= wdata_in;
         bl_ff         <= bl_in;
         wl_ff         <= wl_in;
         block_ff      <= block_in;
         base_ff       <= base_in;
         idx_ff        <= idx_in;
         word_ff       <= word_in;
         pipe_way_ff   <= pipe_way_in;
         pipe_word_ff  <= pipe_word_in;
         hit_way_ff    <= hit_way_in;
         hit_dirty_ff  <= hit_dirty_in;
         hit_age_ff    <= hit_age_in;
         inv_way_ff    <= inv_way_in;
         best_way_ff   <= best_way_in;
         best_age_ff   <= best_age_in;
         best_tag_ff   <= best_tag_in;
         best_dirty_ff <= best_dirty_in;
         way_ff        <= way_in;
         was_valid_ff  <= was_valid_in;
         old_age_ff    <= old_age_in;
      end
      if (reset) begin
         state_ff    <= ST_IDLE;
         pipe_vld_ff <= 1'b0;
         hit_ff      <= 1'b0;
         inv_ff      <= 1'b0;
         valid_ff    <= '0;
      end else begin
         state_ff    <= state_in;
         pipe_vld_ff <= pipe_vld_in;
         hit_ff      <= hit_in;
         inv_ff      <= inv_in;
         valid_ff    <= valid_in;
      end
   end

   `SAWLC_ASSERT(a_emit_slot, clock, reset, emit |-> slot_free)
   `SAWLC_ASSERT(a_meta_rw, clock, reset, (meta_we && meta_re) |-> (meta_waddr != meta_raddr))
   `SAWLC_ASSERT_NEVER(a_mem_rw, clock, reset, mem_we && mem_re)
   `SAWLC_ASSERT(a_inval, clock, reset, invalidate |=> (valid_ff == '0))

endmodule

[sv/set_assoc_writeback_lru_cache_unit.sv]
// ---------------------------------------------------------------------------
// set-associative write-back lru cache
// word-addressed cache with write-allocate in front of a backing memory
// ---------------------------------------------------------------------------
// req_ch takes preloads (written straight to backing memory, no response)
// and cached reads and writes. rsp_ch gives the transfer trace of each
// access: an eviction record (write-back or drop) if a valid line is
// replaced, a fill record on a miss, then the processor word transfer with
// last set. a csr_* write to a geometry register invalidates every line;
// write it only while the unit is idle.
// a preload leaves the unit idle and ready for the next request. a read or
// write hit reads the tag/age ram, one read a cycle, for the scan and again
// for the age update, then does the word access. a miss adds the fill, and
// before it an eviction record when a valid line is replaced, with a copy
// of that line to backing memory first when it is dirty; the data and
// backing rams each move one word a cycle.
// one access is in flight at a time. the response register lets the next
// record be built while the last one waits; a stalled rsp_ch holds the
// sequencer. reset clears the state, geometry and response valid registers
// and all line valid bits at once; backing memory and line data are
// undefined until written.
// ---------------------------------------------------------------------------
module set_assoc_writeback_lru_cache_unit import sawlc_pkg::*; #(
   parameter int MEM_WORDS       = MEM_WORDS_DEF,
   parameter int MAX_LINES       = MAX_LINES_DEF,
   parameter int MAX_BLOCK_WORDS = MAX_BLOCK_WORDS_DEF,
   parameter int MAX_WAYS        = MAX_WAYS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   sawlc_req_if.sink   req_ch,
   sawlc_rsp_if.source rsp_ch,
   input  logic        csr_write_enable,
   input  logic [1:0]  csr_index,
   input  logic [3:0]  csr_write_data
);
   localparam logic [3:0] BLOCK_LOG2 = 4'($clog2(MAX_BLOCK_WORDS));
   localparam logic [3:0] WAYS_LOG2  = 4'($clog2(MAX_WAYS));
   localparam logic [3:0] LINES_LOG2 = 4'($clog2(MAX_LINES));

   logic [2:0] blk_log2_ff, blk_log2_in;
   logic [3:0] sets_log2_ff, sets_log2_in;
   logic [2:0] ways_log2_ff, ways_log2_in;
   logic       invalidate;
   geom_type   geom;
   logic [3:0] wl_sat;
   rec_type    rec, rec_ff, rec_in;
   logic       emit, slot_free;
   logic       rsp_valid_ff, rsp_valid_in;

   always_comb begin
      blk_log2_in  = blk_log2_ff;
      sets_log2_in = sets_log2_ff;
      ways_log2_in = ways_log2_ff;
      invalidate   = 1'b0;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_BLOCK_WORDS_LOG2: begin
               blk_log2_in = csr_write_data[2:0];
               invalidate  = 1'b1;
            end
            CSR_SETS_LOG2: begin
               sets_log2_in = csr_write_data;
               invalidate   = 1'b1;
            end
            CSR_WAYS_LOG2: begin
               ways_log2_in = csr_write_data[2:0];
               invalidate   = 1'b1;
            end
            default: begin
               invalidate = 1'b0;
            end
         endcase
      end
   end

   always_comb begin
      geom.bl = ({1'b0, blk_log2_ff} > BLOCK_LOG2) ? BLOCK_LOG2 : {1'b0, blk_log2_ff};
      wl_sat  = ({1'b0, ways_log2_ff} > WAYS_LOG2) ? WAYS_LOG2 : {1'b0, ways_log2_ff};
      geom.wl = (wl_sat > LINES_LOG2) ? LINES_LOG2 : wl_sat;
      geom.sl = (sets_log2_ff > LINES_LOG2 - geom.wl) ? LINES_LOG2 - geom.wl : sets_log2_ff;
   end

   sawlc_ctrl #(
      .MEM_WORDS(MEM_WORDS), .MAX_LINES(MAX_LINES),
      .MAX_BLOCK_WORDS(MAX_BLOCK_WORDS), .MAX_WAYS(MAX_WAYS)
   ) u_ctrl (
      .clock, .reset, .geom, .invalidate, .req_ch, .slot_free, .emit, .rec
   );

   assign slot_free    = !rsp_valid_ff || rsp_ch.ready;
   assign rsp_valid_in = emit ? 1'b1 : (rsp_valid_ff && !rsp_ch.ready);
   assign rec_in       = emit ? rec : rec_ff;

   always_ff @(posedge clock) begin
      rec_ff <= rec_in;
      if (reset) begin
         blk_log2_ff  <= '0;
         sets_log2_ff <= '0;
         ways_log2_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         blk_log2_ff  <= blk_log2_in;
         sets_log2_ff <= sets_log2_in;
         ways_log2_ff <= ways_log2_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.transfer_kind  = rec_ff.kind;
   assign rsp_ch.start_address  = rec_ff.start;
   assign rsp_ch.transfer_words = rec_ff.words;
   assign rsp_ch.read_data      = rec_ff.data;
   assign rsp_ch.last           = rec_ff.last;

endmodule
